[hw/rtl/assert_macros.svh]
// Assertion helper macros shared by the short-name encoder RTL.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: condition does not hold");

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/snenc_pkg.sv]
// Package for the short-name encoder: widths, character codes, item classes
// and the queue entry types shared by the front and back. No dependencies.
`default_nettype none

package snenc_pkg;

   localparam int CHR_W    = 8;
   localparam int NAME_LEN = 11;
   localparam int BASE_LEN = 8;
   localparam int EXT_LEN  = NAME_LEN - BASE_LEN;
   localparam int IDX_W    = $clog2(NAME_LEN + 1);
   localparam int BASE_W   = BASE_LEN * CHR_W;
   localparam int EXT_W    = EXT_LEN * CHR_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHR_W-1:0] CHR_NUL     = 8'h00;
   localparam logic [CHR_W-1:0] CHR_SPACE   = 8'h20;
   localparam logic [CHR_W-1:0] CHR_PRINT_LO = 8'h21;
   localparam logic [CHR_W-1:0] CHR_PRINT_HI = 8'h7E;
   localparam logic [CHR_W-1:0] CHR_QUOTE   = 8'h22;
   localparam logic [CHR_W-1:0] CHR_STAR    = 8'h2A;
   localparam logic [CHR_W-1:0] CHR_COMMA   = 8'h2C;
   localparam logic [CHR_W-1:0] CHR_DOT     = 8'h2E;
   localparam logic [CHR_W-1:0] CHR_SLASH   = 8'h2F;
   localparam logic [CHR_W-1:0] CHR_COLON   = 8'h3A;
   localparam logic [CHR_W-1:0] CHR_QMARK   = 8'h3F;
   localparam logic [CHR_W-1:0] CHR_LBRACK  = 8'h5B;
   localparam logic [CHR_W-1:0] CHR_RBRACK  = 8'h5D;
   localparam logic [CHR_W-1:0] CHR_LOWER_A = 8'h61;
   localparam logic [CHR_W-1:0] CHR_LOWER_Z = 8'h7A;
   localparam logic [CHR_W-1:0] CHR_PIPE    = 8'h7C;
   localparam logic [CHR_W-1:0] CASE_OFFSET = 8'h20;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;
   localparam logic TERM_NUL   = 1'b0;
   localparam logic TERM_SLASH = 1'b1;

   typedef enum logic [2:0] {
      CLS_CHAR,
      CLS_DOT,
      CLS_TERM_NUL,
      CLS_TERM_SLASH,
      CLS_BAD
   } cls_type;

   typedef struct packed {
      logic             start;
      cls_type          cls;
      logic [CHR_W-1:0] chr;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

`default_nettype wire

[hw/rtl/snenc_req_if.sv]
// Input channel of the short-name encoder: one path character per item.
// Depends on snenc_pkg for the character width.
`default_nettype none

interface snenc_req_if;
   logic                        valid;
   logic                        ready;
   logic [snenc_pkg::CHR_W-1:0] ch;
   logic                        start_req;

   modport source (output valid, output ch, output start_req, input ready);
   modport sink   (input valid, input ch, input start_req, output ready);
endinterface

`default_nettype wire

[hw/rtl/snenc_rsp_if.sv]
// Result channel of the short-name encoder: status, terminator and 8.3 name.
// Depends on snenc_pkg for the field widths.
`default_nettype none

interface snenc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic                         terminator;
   logic [snenc_pkg::BASE_W-1:0] base_name;
   logic [snenc_pkg::EXT_W-1:0]  extension;

   modport source (output valid, output status, output terminator,
                   output base_name, output extension, input ready);
   modport sink   (input valid, input status, input terminator,
                   input base_name, input extension, output ready);
endinterface

`default_nettype wire

[hw/rtl/snenc_front.sv]
// Front end: accepts characters, classifies them and queues them for the back.
// Depends on snenc_pkg, snenc_req_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module snenc_front (
   input  wire logic           clock,
   input  wire logic           reset,
   snenc_req_if.sink           req_chan,
   input  wire logic           pop,
   output snenc_pkg::head_type head
);

   snenc_pkg::entry_type                 queue_ff [snenc_pkg::QUEUE_DEPTH];
   logic [snenc_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [snenc_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [snenc_pkg::QCNT_W-1:0]         count_ff, count_in;
   snenc_pkg::cls_type                   cls;
   logic [snenc_pkg::CHR_W-1:0]          chr_up;
   logic                                 forbidden;
   logic                                 push;

   // Classify the incoming character
   always_comb begin
      forbidden = (req_chan.ch == snenc_pkg::CHR_QUOTE) ||
                  (req_chan.ch >= snenc_pkg::CHR_STAR   && req_chan.ch <= snenc_pkg::CHR_COMMA) ||
                  (req_chan.ch == snenc_pkg::CHR_SLASH) ||
                  (req_chan.ch >= snenc_pkg::CHR_COLON  && req_chan.ch <= snenc_pkg::CHR_QMARK) ||
                  (req_chan.ch >= snenc_pkg::CHR_LBRACK && req_chan.ch <= snenc_pkg::CHR_RBRACK) ||
                  (req_chan.ch == snenc_pkg::CHR_PIPE);
      if (req_chan.ch == snenc_pkg::CHR_NUL) begin
         cls = snenc_pkg::CLS_TERM_NUL;
      end else if (req_chan.ch == snenc_pkg::CHR_SLASH) begin
         cls = snenc_pkg::CLS_TERM_SLASH;
      end else if (req_chan.ch < snenc_pkg::CHR_PRINT_LO ||
                   req_chan.ch > snenc_pkg::CHR_PRINT_HI) begin
         cls = snenc_pkg::CLS_BAD;
      end else if (req_chan.ch == snenc_pkg::CHR_DOT) begin
         cls = snenc_pkg::CLS_DOT;
      end else if (forbidden) begin
         cls = snenc_pkg::CLS_BAD;
      end else begin
         cls = snenc_pkg::CLS_CHAR;
      end
      if (req_chan.ch >= snenc_pkg::CHR_LOWER_A && req_chan.ch <= snenc_pkg::CHR_LOWER_Z) begin
         chr_up = req_chan.ch - snenc_pkg::CASE_OFFSET;
      end else begin
         chr_up = req_chan.ch;
      end
   end

   assign req_chan.ready = (count_ff != snenc_pkg::QCNT_W'(snenc_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         if (wr_ptr_ff == snenc_pkg::QPTR_W'(snenc_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + snenc_pkg::QPTR_W'(1);
         end
      end
      if (pop) begin
         if (rd_ptr_ff == snenc_pkg::QPTR_W'(snenc_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + snenc_pkg::QPTR_W'(1);
         end
      end
      if (push && !pop) begin
         count_in = count_ff + snenc_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - snenc_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{start: req_chan.start_req, cls: cls, chr: chr_up};
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= snenc_pkg::QCNT_W'(snenc_pkg::QUEUE_DEPTH))
   `ASSERT_IMPLY(a_pop_needs_item, clock, reset, pop, count_ff != '0)
   `ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + snenc_pkg::QCNT_W'(1))

endmodule

`default_nettype wire

[hw/rtl/snenc_back.sv]
// Back end: applies queued character classes to the name buffer and registers
// the result. Depends on snenc_pkg, snenc_rsp_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module snenc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire snenc_pkg::head_type head,
   output logic                     pop,
   snenc_rsp_if.source              rsp_chan
);

   logic [snenc_pkg::CHR_W-1:0] name_ff [snenc_pkg::NAME_LEN];
   logic [snenc_pkg::CHR_W-1:0] name_in [snenc_pkg::NAME_LEN];
   logic [snenc_pkg::IDX_W-1:0] write_index_ff, write_index_in;
   logic                        in_ext_ff, in_ext_in;
   logic                        active_ff, active_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        status_ff, status_in;
   logic                        term_ff, term_in;
   logic [snenc_pkg::BASE_W-1:0] base_ff, base_in;
   logic [snenc_pkg::EXT_W-1:0]  ext_ff, ext_in;
   logic                         emit;
   logic                         at_limit;

   // Take the next item whenever the output register is free or draining
   assign pop = head.valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      name_in        = name_ff;
      write_index_in = write_index_ff;
      in_ext_in      = in_ext_ff;
      active_in      = active_ff;
      emit           = 1'b0;
      status_in      = snenc_pkg::STATUS_BAD;
      term_in        = snenc_pkg::TERM_NUL;
      base_in        = '0;
      ext_in         = '0;
      at_limit       = 1'b0;
      if (pop) begin
         if (head.entry.start) begin
            for (int i = 0; i < snenc_pkg::NAME_LEN; i++) begin
               name_in[i] = snenc_pkg::CHR_SPACE;
            end
            write_index_in = '0;
            in_ext_in      = 1'b0;
            active_in      = 1'b1;
         end
         at_limit = in_ext_in ?
                    (write_index_in >= snenc_pkg::IDX_W'(snenc_pkg::NAME_LEN)) :
                    (write_index_in >= snenc_pkg::IDX_W'(snenc_pkg::BASE_LEN));
         if (active_in) begin
            case (head.entry.cls)
               snenc_pkg::CLS_TERM_NUL, snenc_pkg::CLS_TERM_SLASH: begin
                  emit      = 1'b1;
                  active_in = 1'b0;
                  if (write_index_in != '0) begin
                     status_in = snenc_pkg::STATUS_OK;
                     term_in   = (head.entry.cls == snenc_pkg::CLS_TERM_SLASH) ?
                                 snenc_pkg::TERM_SLASH : snenc_pkg::TERM_NUL;
                     for (int i = 0; i < snenc_pkg::BASE_LEN; i++) begin
                        base_in[snenc_pkg::BASE_W - 1 - i * snenc_pkg::CHR_W -: snenc_pkg::CHR_W]
                           = name_in[i];
                     end
                     for (int i = 0; i < snenc_pkg::EXT_LEN; i++) begin
                        ext_in[snenc_pkg::EXT_W - 1 - i * snenc_pkg::CHR_W -: snenc_pkg::CHR_W]
                           = name_in[snenc_pkg::BASE_LEN + i];
                     end
                  end
               end
               snenc_pkg::CLS_DOT: begin
                  if (!in_ext_in) begin
                     write_index_in = snenc_pkg::IDX_W'(snenc_pkg::BASE_LEN);
                     in_ext_in      = 1'b1;
                  end else begin
                     emit      = 1'b1;
                     active_in = 1'b0;
                  end
               end
               snenc_pkg::CLS_CHAR: begin
                  if (at_limit) begin
                     emit      = 1'b1;
                     active_in = 1'b0;
                  end else begin
                     for (int i = 0; i < snenc_pkg::NAME_LEN; i++) begin
                        if (write_index_in == snenc_pkg::IDX_W'(i)) begin
                           name_in[i] = head.entry.chr;
                        end
                     end
                     write_index_in = write_index_in + snenc_pkg::IDX_W'(1);
                  end
               end
               default: begin
                  emit      = 1'b1;
                  active_in = 1'b0;
               end
            endcase
         end
      end
      rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < snenc_pkg::NAME_LEN; i++) begin
            name_ff[i] <= snenc_pkg::CHR_SPACE;
         end
         write_index_ff <= '0;
         in_ext_ff      <= 1'b0;
         active_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         name_ff        <= name_in;
         write_index_ff <= write_index_in;
         in_ext_ff      <= in_ext_in;
         active_ff      <= active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload: load only when a new result is produced
   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff <= status_in;
         term_ff   <= term_in;
         base_ff   <= base_in;
         ext_ff    <= ext_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.terminator = term_ff;
   assign rsp_chan.base_name  = base_ff;
   assign rsp_chan.extension  = ext_ff;

   `ASSERT_ALWAYS(a_index_bound, clock, reset, write_index_ff <= snenc_pkg::IDX_W'(snenc_pkg::NAME_LEN))
   `ASSERT_IMPLY(a_base_index, clock, reset, !in_ext_ff, write_index_ff <= snenc_pkg::IDX_W'(snenc_pkg::BASE_LEN))
   `ASSERT_IMPLY(a_no_pop_stalled, clock, reset, rsp_valid_ff && !rsp_chan.ready, !pop)

endmodule

`default_nettype wire

[hw/rtl/short_name_8_3_encoder_top.sv]
// Top level of the FAT 8.3 short-name encoder.
// Depends on snenc_pkg, snenc_req_if, snenc_rsp_if, snenc_front and snenc_back.
`default_nettype none

// Feed one path character per item on req_chan; set start_req on the first
// character of each name to clear the buffer and begin. The block takes one
// item per clock cycle for as long as results are taken. The item that ends
// a name is registered in the front queue when accepted; the back works on
// it while it sits at the head of that queue, and the result lands in the
// back's output register, which drives rsp_chan and from which it can be
// taken once rsp_chan.valid is high. The front
// classifies each character (terminator, dot, plain, bad) and raises lower
// case; a two-entry queue sits between it and the back, which owns the
// eleven-byte name buffer, the write index and the base/extension flag. When
// the output register is full and not being taken, the back holds and the
// queue absorbs up to two further items before req_chan.ready drops. A NUL
// or slash after at least one character or dot gives status 0 with the
// space-padded base and extension, first character in the top byte; any bad
// character, second dot, overflow or empty name gives status 1 with all other
// fields zero. After either result, items are dropped until the next start.

module short_name_8_3_encoder_top (
   input wire logic    clock,
   input wire logic    reset,
   snenc_req_if.sink   req_chan,
   snenc_rsp_if.source rsp_chan
);

   // Queue head seen by the back, and the back's take strobe
   snenc_pkg::head_type head;
   logic                pop;

   snenc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head     (head)
   );

   snenc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// Testbench for short_name_8_3_encoder_top: streams path characters into the
// encoder, predicts each 8.3 name result item and checks it field by field.
// Depends on snenc_pkg, snenc_req_if, snenc_rsp_if and the encoder RTL.

module testbench;
   import snenc_pkg::*;

   typedef logic [CHR_W-1:0] char_t;
   typedef char_t char_seq_t[$];

   // One expected result item, laid out like the result channel.
   typedef struct packed {
      logic              status;
      logic              terminator;
      logic [BASE_W-1:0] base_name;
      logic [EXT_W-1:0]  extension;
   } name_result_t;

   // What one accepted character does to the name being built.
   typedef enum logic [1:0] {
      STEP_IGNORED,
      STEP_HELD,
      STEP_RESULT
   } step_kind_t;

   localparam int RANDOM_ITEMS    = 900;
   localparam int FULL_RATE_ITEMS = 80;
   localparam int LONG_HOLD       = 48;
   localparam int SETTLE_CYCLES   = 8;
   localparam int MAX_REPORTS     = 40;

   logic clock;
   logic reset;

   snenc_req_if req_chan();
   snenc_rsp_if rsp_chan();

   short_name_8_3_encoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 2 ns period: low for 1 ns, high for 1 ns.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Predicted encoder state: the eleven name bytes, the next write slot,
   // the end of the field being filled and whether a name is open.
   char_t              name_bytes [NAME_LEN];
   logic [IDX_W-1:0]   fill_pos;
   logic [IDX_W-1:0]   fill_end;
   logic               name_open;

   name_result_t       pending_names[$];   // results owed by the encoder, oldest first
   int                 taken_items;        // accepted items that the encoder did not ignore
   int                 error_count;
   bit                 idling;             // random gaps on both sides when set
   bit                 hold_off_request;   // ask the result side for one long stall

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Characters that FAT forbids in a short name; the dot is here too, since
   // only the first dot of a name is taken as the base/extension split.
   function automatic logic is_forbidden(input char_t c);
      return c == CHR_QUOTE || (c >= CHR_STAR && c <= CHR_COMMA) || c == CHR_DOT ||
             c == CHR_SLASH || (c >= CHR_COLON && c <= CHR_QMARK) ||
             (c >= CHR_LBRACK && c <= CHR_RBRACK) || c == CHR_PIPE;
   endfunction

   function automatic void clear_name();
      int i;
      for (i = 0; i < NAME_LEN; i++)
         name_bytes[i] = CHR_SPACE;
      fill_pos = '0;
      fill_end = IDX_W'(BASE_LEN);
   endfunction

   // Advance the predicted state by one accepted item; fill res when the item
   // closes the name, either complete or invalid.
   function automatic step_kind_t encode_char(input char_t c_in, input logic start,
                                              output name_result_t res);
      char_t c;
      logic  bad;
      int    i;
      c   = c_in;
      bad = 1'b0;
      res = '0;
      if (start) begin
         clear_name();
         name_open = 1'b1;
      end
      if (!name_open)
         return STEP_IGNORED;

      // A NUL or slash ends the name once anything, even a lone dot, is in.
      if ((c == CHR_NUL || c == CHR_SLASH) && fill_pos != 0) begin
         res.status     = STATUS_OK;
         res.terminator = (c == CHR_SLASH) ? TERM_SLASH : TERM_NUL;
         for (i = 0; i < BASE_LEN; i++)
            res.base_name = {res.base_name[BASE_W-CHR_W-1:0], name_bytes[i]};
         for (i = BASE_LEN; i < NAME_LEN; i++)
            res.extension = {res.extension[EXT_W-CHR_W-1:0], name_bytes[i]};
         name_open = 1'b0;
         return STEP_RESULT;
      end

      if (c < CHR_PRINT_LO || c > CHR_PRINT_HI) begin
         bad = 1'b1;
      end else if (c == CHR_DOT && fill_end == IDX_W'(BASE_LEN)) begin
         // first dot: jump to the extension, whatever the base length
         fill_pos = IDX_W'(BASE_LEN);
         fill_end = IDX_W'(NAME_LEN);
      end else if (is_forbidden(c)) begin
         bad = 1'b1;
      end else begin
         if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
            c = c - CASE_OFFSET;
         if (fill_pos >= fill_end) begin
            bad = 1'b1;
         end else begin
            name_bytes[fill_pos] = c;
            fill_pos = fill_pos + 1'b1;
         end
      end

      if (bad) begin
         res.status = STATUS_BAD;
         name_open  = 1'b0;
         return STEP_RESULT;
      end
      return STEP_HELD;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Mostly no gap, some short ones, a few long ones; none with idling off.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idling)
         return 0;
      roll = $urandom_range(99);
      if (roll < 60)
         return 0;
      if (roll < 88)
         return $urandom_range(3, 1);
      if (roll < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic char_t name_char();
      char_t c;
      do
         c = char_t'($urandom_range(CHR_PRINT_HI, CHR_PRINT_LO));
      while (is_forbidden(c));
      return c;
   endfunction

   // Anything that is not a plain name character: controls, high bytes,
   // forbidden punctuation, dots, slashes and NUL.
   function automatic char_t bad_char();
      char_t c;
      do
         c = char_t'($urandom_range(255));
      while (c >= CHR_PRINT_LO && c <= CHR_PRINT_HI && !is_forbidden(c));
      return c;
   endfunction

   function automatic char_t terminator_char();
      return ($urandom_range(1) != 0) ? CHR_SLASH : CHR_NUL;
   endfunction

   function automatic char_seq_t good_name();
      char_seq_t seq;
      int        base_len;
      logic      dotted;
      base_len = $urandom_range(BASE_LEN);
      dotted   = (base_len == 0) || ($urandom_range(1) != 0);
      repeat (base_len) seq.push_back(name_char());
      if (dotted) begin
         seq.push_back(CHR_DOT);
         repeat ($urandom_range(EXT_LEN)) seq.push_back(name_char());
      end
      seq.push_back(terminator_char());
      return seq;
   endfunction

   // A name spoilt in one way: base or extension too long, one bad character
   // dropped in, a second dot, or no terminator so the next start cuts it off.
   function automatic char_seq_t broken_name();
      char_seq_t seq;
      int        roll;
      int        pos;
      roll = $urandom_range(99);
      if (roll < 20) begin
         repeat ($urandom_range(BASE_LEN + 4, BASE_LEN + 1)) seq.push_back(name_char());
         seq.push_back(terminator_char());
      end else if (roll < 40) begin
         repeat ($urandom_range(BASE_LEN, 1)) seq.push_back(name_char());
         seq.push_back(CHR_DOT);
         repeat ($urandom_range(EXT_LEN + 3, EXT_LEN + 1)) seq.push_back(name_char());
         seq.push_back(terminator_char());
      end else if (roll < 65) begin
         seq = good_name();
         pos = $urandom_range(seq.size() - 1);
         seq.insert(pos, bad_char());
      end else if (roll < 80) begin
         repeat ($urandom_range(BASE_LEN)) seq.push_back(name_char());
         seq.push_back(CHR_DOT);
         repeat ($urandom_range(EXT_LEN)) seq.push_back(name_char());
         seq.push_back(CHR_DOT);
         seq.push_back(name_char());
         seq.push_back(terminator_char());
      end else begin
         seq = good_name();
         void'(seq.pop_back());
      end
      return seq;
   endfunction

   // ---------------------------------------------------------------------------
   // Driving and checking
   // ---------------------------------------------------------------------------

   // Offer one item, hold it until accepted, then book what it should cause.
   // Returns at the edge that took the item, with valid still high.
   task automatic send_char(input char_t c, input logic start);
      int unsigned  gap;
      name_result_t res;
      step_kind_t   kind;
      gap = pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.ch        <= c;
      req_chan.start_req <= start;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      kind = encode_char(c, start, res);
      if (kind == STEP_RESULT)
         pending_names.push_back(res);
      if (kind != STEP_IGNORED)
         taken_items++;
   endtask

   // Send a whole path name: start on the first character only.
   task automatic send_name(input char_seq_t seq);
      int i;
      for (i = 0; i < seq.size(); i++)
         send_char(seq[i], i == 0);
   endtask

   // Drop valid and hold off until every owed result has come back.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_names.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [BASE_W-1:0] got,
                                  input logic [BASE_W-1:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s: got %h, expected %h", $time, what, got, want);
   endtask

   task automatic check_result();
      name_result_t want;
      if (pending_names.size() == 0) begin
         report_mismatch("result item with none owed", rsp_chan.base_name, '0);
         return;
      end
      want = pending_names.pop_front();
      if (rsp_chan.status !== want.status)
         report_mismatch("status", BASE_W'(rsp_chan.status), BASE_W'(want.status));
      if (rsp_chan.terminator !== want.terminator)
         report_mismatch("terminator", BASE_W'(rsp_chan.terminator),
                         BASE_W'(want.terminator));
      if (rsp_chan.base_name !== want.base_name)
         report_mismatch("base_name", rsp_chan.base_name, want.base_name);
      if (rsp_chan.extension !== want.extension)
         report_mismatch("extension", BASE_W'(rsp_chan.extension),
                         BASE_W'(want.extension));
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Hand-picked names for the edges: top printable byte, lower case, slash
   // end, empty name, slash before anything, a dot alone, high and control
   // bytes, a character while no name is open, a second dot, an over-long
   // extension, and forbidden punctuation.
   task automatic test_directed();
      char_seq_t seq;
      idling = 1'b0;
      seq = {CHR_PRINT_HI, CHR_LOWER_Z, CHR_SLASH};
      send_name(seq);
      seq = {CHR_NUL};
      send_name(seq);
      seq = {CHR_SLASH};
      send_name(seq);
      seq = {CHR_DOT, CHR_NUL};
      send_name(seq);
      seq = {char_t'(8'hFF)};
      send_name(seq);
      seq = {CHR_PRINT_LO, CHR_SPACE};
      send_name(seq);
      // no name open: this one must vanish without a result
      send_char(CHR_LOWER_A, 1'b0);
      seq = {CHR_LOWER_A, CHR_DOT, char_t'(8'h62), CHR_DOT};
      send_name(seq);
      seq = {char_t'(8'h41), CHR_DOT, char_t'(8'h42), char_t'(8'h43), char_t'(8'h44),
             char_t'(8'h45)};
      send_name(seq);
      seq = {CHR_PIPE};
      send_name(seq);
      seq = {char_t'(8'h7F)};
      send_name(seq);
   endtask

   // Mostly well-formed names with random content, the rest spoilt names,
   // raw noise and stray characters after a name has closed.
   task automatic test_random_names(input int count, input bit with_idling);
      int target;
      int roll;
      idling = with_idling;
      target = taken_items + count;
      while (taken_items < target) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            send_name(good_name());
         end else if (roll < 85) begin
            send_name(broken_name());
         end else if (roll < 95) begin
            repeat ($urandom_range(6, 1))
               send_char(char_t'($urandom_range(255)), $urandom_range(3) == 0);
         end else begin
            repeat ($urandom_range(3, 1)) send_char(name_char(), 1'b0);
         end
      end
   endtask

   // Stall the result side for a long stretch while one-character names keep
   // coming, so the inner queue fills and the input side backs up.
   task automatic test_output_hold_off();
      char_seq_t seq;
      idling = 1'b0;
      hold_off_request = 1'b1;
      repeat (15) begin
         seq = {name_char(), terminator_char()};
         send_name(seq);
      end
   endtask

   // Twice over, send three names, then go quiet until the encoder has answered them all.
   task automatic test_drain_pause();
      idling = 1'b1;
      repeat (2) begin
         repeat (3) send_name(good_name());
         wait_for_results();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side: take result items with random stalls, and one long hold-off
   // on request, counted here in cycles.
   // ---------------------------------------------------------------------------
   initial begin : result_side
      int unsigned stall_left;
      int unsigned gap;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            check_result();
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left       = LONG_HOLD;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            gap = pick_gap();
            rsp_chan.ready <= (gap == 0);
            stall_left = (gap == 0) ? 0 : gap - 1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : run
      req_chan.valid     = 1'b0;
      req_chan.ch        = CHR_NUL;
      req_chan.start_req = 1'b0;
      idling             = 1'b0;
      hold_off_request   = 1'b0;
      taken_items        = 0;
      error_count        = 0;
      clear_name();
      name_open = 1'b0;

      // hold reset asserted, then release it at a clock edge
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_names(RANDOM_ITEMS, 1'b1);
      test_output_hold_off();
      test_random_names(FULL_RATE_ITEMS, 1'b0);
      test_drain_pause();

      // drain, then keep watching for any stray result item before the verdict
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Give up well past the slowest correct run, in which every item waits out
   // the longest gaps on both sides.
   initial begin : watchdog
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
